@@ design/mbd_pkg.sv @@
package mbd_pkg;

  localparam int TABLE_WORDS_DEF  = 624;
  localparam int SHIFT_OFFSET_DEF = 397;

  localparam logic [31:0] SEED_MULT    = 32'd69069;
  localparam logic [31:0] DEFAULT_SEED = 32'd32767;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  function automatic logic [31:0] mbd_temper(input logic [31:0] y);
    logic [31:0] t;
    t = y ^ (y >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

@@ design/mbd_ram.sv @@
module mbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/mt19937_bounded_draw.sv @@
// MT19937 draw engine with bounded results. Each request is a reseed (kind 1,
// operand is the seed) or a draw (kind 0, operand is the exclusive bound), and
// each gives exactly one result with the value and the draw count since the
// last seeding. The 624-word state table sits in a single-port-read RAM and is
// regenerated lazily: each draw twists just the word it uses, reading its
// three source words one after another. A draw does three table reads, one
// twist/temper step, then a bit-serial remainder. A reseed writes one table
// word per cycle; a draw before any seeding seeds with 32767 first. A draw
// with bound zero returns 0 and changes nothing. A new request is taken
// while a finished result still waits on the output.
module mt19937_bounded_draw
  import mbd_pkg::*;
#(
  parameter int TABLE_WORDS  = TABLE_WORDS_DEF,
  parameter int SHIFT_OFFSET = SHIFT_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [31:0] out_draws_count
);

  localparam int AW       = $clog2(TABLE_WORDS);
  localparam int FAR_WRAP = TABLE_WORDS - SHIFT_OFFSET;
  localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_WORDS - 1);
  localparam logic [AW-1:0] WRAP_IDX   = AW'(FAR_WRAP);
  localparam logic [AW-1:0] OFFSET_IDX = AW'(SHIFT_OFFSET);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEED   = 8'b0000_0010,
    S_RD_CUR = 8'b0000_0100,
    S_RD_NXT = 8'b0000_1000,
    S_RD_FAR = 8'b0001_0000,
    S_TWIST  = 8'b0010_0000,
    S_MOD    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic          seeded_r, seeded_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [31:0]   drawn_r, drawn_nxt;
  logic [31:0]   seed_word_r, seed_word_nxt;
  logic [AW-1:0] seed_idx_r, seed_idx_nxt;
  logic [31:0]   bound_r, bound_nxt;
  logic [31:0]   y_r, y_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [4:0]    div_cnt_r, div_cnt_nxt;
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  logic [31:0]   out_count_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic [AW-1:0] pos_next1;
  logic [AW-1:0] pos_far;
  logic [31:0]   seed_prod;
  logic [31:0]   twisted;
  logic [32:0]   trial;
  logic [32:0]   trial_diff;
  logic          out_free;
  logic          in_fire;

  mbd_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_WORDS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign pos_next1 = (pos_r == LAST_IDX) ? '0 : pos_r + AW'(1);
  assign pos_far   = (pos_r < WRAP_IDX) ? pos_r + OFFSET_IDX : pos_r - WRAP_IDX;
  assign seed_prod = 32'(seed_word_r * SEED_MULT);

  // words below pos_r already hold the new generation, so plain reads match a full pass
  assign twisted = rd_data ^ (y_r >> 1) ^ (y_r[0] ? TWIST_MATRIX : 32'd0);

  assign trial      = {rem_r, quo_r[31]};
  assign trial_diff = trial - {1'b0, bound_r};

  assign wr_en   = (state_r == S_SEED) || (state_r == S_TWIST);
  assign wr_addr = (state_r == S_SEED) ? seed_idx_r : pos_r;
  assign wr_data = (state_r == S_SEED) ? seed_word_r : twisted;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    rd_addr = pos_r;
    case (state_r)
      S_RD_NXT: rd_addr = pos_next1;
      S_RD_FAR: rd_addr = pos_far;
      default:  rd_addr = pos_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    drawn_nxt     = drawn_r;
    seed_word_nxt = seed_word_r;
    seed_idx_nxt  = seed_idx_r;
    bound_nxt     = bound_r;
    y_nxt         = y_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          bound_nxt    = in_operand;
          seed_idx_nxt = '0;
          if (in_kind == KIND_RESEED) begin
            seed_word_nxt = in_operand;
            pend_nxt      = 1'b0;
            state_nxt     = S_SEED;
          end else if (in_operand == 32'd0) begin
            rem_nxt   = '0;
            state_nxt = S_OUT;
          end else if (!seeded_r) begin
            seed_word_nxt = DEFAULT_SEED;
            pend_nxt      = 1'b1;
            state_nxt     = S_SEED;
          end else begin
            state_nxt = S_RD_CUR;
          end
        end
      end
      S_SEED: begin
        seed_word_nxt = seed_prod;
        seed_idx_nxt  = seed_idx_r + AW'(1);
        if (seed_idx_r == LAST_IDX) begin
          seeded_nxt = 1'b1;
          pos_nxt    = '0;
          drawn_nxt  = '0;
          rem_nxt    = '0;
          state_nxt  = pend_r ? S_RD_CUR : S_OUT;
        end
      end
      S_RD_CUR: state_nxt = S_RD_NXT;
      S_RD_NXT: begin
        y_nxt     = rd_data & UPPER_MASK;
        state_nxt = S_RD_FAR;
      end
      S_RD_FAR: begin
        y_nxt     = y_r | (rd_data & LOWER_MASK);
        state_nxt = S_TWIST;
      end
      S_TWIST: begin
        quo_nxt     = mbd_temper(twisted);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        pos_nxt     = pos_next1;
        drawn_nxt   = drawn_r + 32'd1;
        state_nxt   = S_MOD;
      end
      S_MOD: begin
        // restoring remainder, one dividend bit per cycle
        rem_nxt     = trial_diff[32] ? trial[31:0] : trial_diff[31:0];
        quo_nxt     = {quo_r[30:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seeded_r    <= 1'b0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      drawn_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
      pend_r   <= pend_nxt;
      pos_r    <= pos_nxt;
      drawn_r  <= drawn_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seed_word_r <= seed_word_nxt;
    seed_idx_r  <= seed_idx_nxt;
    bound_r     <= bound_nxt;
    y_r         <= y_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    if (state_r == S_OUT && out_free) begin
      out_value_r <= rem_r;
      out_count_r <= drawn_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_draws_count = out_count_r;

`ifndef ASSERT_OFF
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SEED || state_r == S_TWIST))
    else $error("table written outside seeding or twist");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_IDX)
    else $error("read position out of table");

  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEED && seed_idx_r == LAST_IDX) |=>
      (seeded_r && pos_r == '0 && drawn_r == 32'd0))
    else $error("seeding did not rewind position and count");

  a_draw_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TWIST) |=> (drawn_r == $past(drawn_r) + 32'd1))
    else $error("draw count not advanced by one");

  a_unseeded_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_CUR) |-> seeded_r)
    else $error("table read before seeding");
`endif

endmodule
